>>> design/lrup_pkg.sv
// ----------------------------------------------------------------------------
// lrup_pkg
// Shared widths, constants and control types for the LRU page replacement
// block and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package lrup_pkg;

   // Defaults for the top-level parameters
   localparam int FRAMES_DEF    = 16;
   localparam int PAGE_BITS_DEF = 16;

   // Fixed port field widths
   localparam int PAGE_W = 16;
   localparam int SLOT_W = 4;
   localparam int CNT_W  = 32;
   localparam int CSR_W  = 5;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(16);
   localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

   // Control from the sequencer into the scan unit
   typedef struct packed {
      logic clear;   // start a new item: drop all tracked results
      logic sample;  // an entry read from memory is present this cycle
   } lrup_scan_ctl_type;

   // Flags that the scan unit hands back to the sequencer
   typedef struct packed {
      logic hit_found;
      logic empty_found;
      logic min_found;
   } lrup_scan_flags_type;

endpackage : lrup_pkg

`default_nettype wire

>>> design/lrup_ram.sv
// ----------------------------------------------------------------------------
// lrup_ram
// Generic single-write, single-read synchronous RAM with registered read
// data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrup_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : lrup_ram

`default_nettype wire

>>> design/lrup_scan.sv
// ----------------------------------------------------------------------------
// lrup_scan
// Per-entry scan unit: takes one frame entry a cycle from the page and stamp
// memories and tracks the first matching frame, the first empty frame and
// the valid frame with the smallest last-use stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lrup_scan #(
   parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF,
   parameter int IDX_W     = 4
) (
   input  wire logic                      clock,
   input  wire lrup_pkg::lrup_scan_ctl_type ctl,
   input  wire logic [IDX_W-1:0]          entry_idx,
   input  wire logic                      entry_valid,
   input  wire logic [PAGE_BITS-1:0]      entry_page,
   input  wire logic [lrup_pkg::CNT_W-1:0] entry_stamp,
   input  wire logic [PAGE_BITS-1:0]      ref_page,
   output lrup_pkg::lrup_scan_flags_type  flags,
   output logic      [IDX_W-1:0]          hit_idx,
   output logic      [IDX_W-1:0]          empty_idx,
   output logic      [IDX_W-1:0]          min_idx,
   output logic      [PAGE_BITS-1:0]      min_page
);

   import lrup_pkg::*;

   lrup_scan_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]     empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;
   logic [PAGE_BITS-1:0] min_page_ff, min_page_in;
   logic [CNT_W-1:0]     min_stamp_ff, min_stamp_in;

   // Fold one entry into the tracked results
   always_comb begin
      flags_in     = flags_ff;
      hit_idx_in   = hit_idx_ff;
      empty_idx_in = empty_idx_ff;
      min_idx_in   = min_idx_ff;
      min_page_in  = min_page_ff;
      min_stamp_in = min_stamp_ff;
      if (ctl.clear) begin
         flags_in = '0;
      end else if (ctl.sample) begin
         // lowest-indexed resident copy wins
         if (!flags_ff.hit_found && entry_valid && (entry_page == ref_page)) begin
            flags_in.hit_found = 1'b1;
            hit_idx_in         = entry_idx;
         end
         if (!flags_ff.empty_found && !entry_valid) begin
            flags_in.empty_found = 1'b1;
            empty_idx_in         = entry_idx;
         end
         // strict compare keeps the lowest index on equal stamps
         if (entry_valid && (!flags_ff.min_found || (entry_stamp < min_stamp_ff))) begin
            flags_in.min_found = 1'b1;
            min_idx_in         = entry_idx;
            min_page_in        = entry_page;
            min_stamp_in       = entry_stamp;
         end
      end
   end

   // Hold tracked results; flags are cleared at the start of every item
   always_ff @(posedge clock) begin
      flags_ff     <= flags_in;
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      min_idx_ff   <= min_idx_in;
      min_page_ff  <= min_page_in;
      min_stamp_ff <= min_stamp_in;
   end

   assign flags     = flags_ff;
   assign hit_idx   = hit_idx_ff;
   assign empty_idx = empty_idx_ff;
   assign min_idx   = min_idx_ff;
   assign min_page  = min_page_ff;

endmodule : lrup_scan

`default_nettype wire

>>> design/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement with last-use stamps: one result item per page reference.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : page references in; an item is taken when req_valid is high and
//            req_stall is low. req_stall is high while an item is in work.
//   rsp_*  : one result item per reference, held in an output register until
//            taken (rsp_valid high, rsp_stall low). The next reference is
//            taken while a finished result still waits there.
//   csr_*  : write of frames_in_use (0 acts as 1, above FRAMES acts as
//            FRAMES); csr_ready is always high. Write only while idle.
// Operation:
//   With n active frames the sequencer reads one entry a cycle from the page
//   and stamp memories, then decides, writes back and loads the result. A
//   new reference is taken only once the last result is loaded. A result that
//   is stalled at the output holds the following item in its final step.
// Reset:
//   Synchronous, active high. All frames become empty, the request clock and
//   the fault total return to zero, frames_in_use returns to 16. Page and
//   stamp memories are not cleared: only frames marked valid are used.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
   parameter int FRAMES    = lrup_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [lrup_pkg::PAGE_W-1:0] req_page_number,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_hit,
   output logic      [lrup_pkg::SLOT_W-1:0] rsp_frame_slot,
   output logic                             rsp_evicted_valid,
   output logic      [lrup_pkg::PAGE_W-1:0] rsp_evicted_page,
   output logic      [lrup_pkg::CNT_W-1:0]  rsp_fault_count,
   // configuration write channel
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [lrup_pkg::CSR_W-1:0]  csr_data
);

   import lrup_pkg::*;

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_COMMIT,
      ST_PUSH
   } state_type;

   state_type            state_ff;
   logic [CSR_W-1:0]     csr_ff;
   logic [FRAMES-1:0]    valid_ff;
   logic [CNT_W-1:0]     req_clock_ff;
   logic [CNT_W-1:0]     fault_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     cnt_ff;
   logic [IDX_W-1:0]     last_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 rsp_valid_ff;

   // held result between commit and output load
   logic                 res_hit_ff;
   logic [IDX_W-1:0]     res_slot_ff;
   logic                 res_evv_ff;
   logic [PAGE_W-1:0]    res_evp_ff;

   // output payload registers
   logic                 rsp_hit_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_evv_ff;
   logic [PAGE_W-1:0]    rsp_evp_ff;
   logic [CNT_W-1:0]     rsp_fault_ff;

   logic                 accept;
   logic                 out_free;
   logic [31:0]          page_wide;
   logic [PAGE_BITS-1:0] page_in;
   logic [31:0]          n_wide;
   logic [IDX_W-1:0]     last_in;
   logic [CNT_W-1:0]     clock_inc;

   lrup_scan_ctl_type    scan_ctl;
   lrup_scan_flags_type  scan_flags;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     empty_idx;
   logic [IDX_W-1:0]     min_idx;
   logic [PAGE_BITS-1:0] min_page;

   logic [PAGE_BITS-1:0] rd_page;
   logic [CNT_W-1:0]     rd_stamp;

   logic                 miss;
   logic                 evict;
   logic [IDX_W-1:0]     slot;
   logic [31:0]          old_page_wide;
   logic [31:0]          slot_wide;
   logic                 commit;
   logic                 rd_en;

   // Handshakes
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Take the reference to PAGE_BITS bits
   assign page_wide = 32'(req_page_number);
   assign page_in   = page_wide[PAGE_BITS-1:0];

   // Active frame count: zero acts as one, clip to FRAMES
   always_comb begin
      if (csr_ff == '0) begin
         n_wide = 32'd1;
      end else if (32'(csr_ff) > 32'(FRAMES)) begin
         n_wide = 32'(FRAMES);
      end else begin
         n_wide = 32'(csr_ff);
      end
   end
   assign last_in   = IDX_W'(n_wide - 32'd1);
   assign clock_inc = (req_clock_ff == CNT_MAX) ? req_clock_ff : req_clock_ff + CNT_W'(1);

   // Replacement decision from the scan results
   assign commit = (state_ff == ST_COMMIT);
   assign miss   = !scan_flags.hit_found;
   assign evict  = miss && !scan_flags.empty_found;
   always_comb begin
      if (scan_flags.hit_found) begin
         slot = hit_idx;
      end else if (scan_flags.empty_found) begin
         slot = empty_idx;
      end else begin
         slot = min_idx;
      end
   end
   assign old_page_wide = 32'(min_page);
   assign slot_wide     = 32'(res_slot_ff);

   // Scan control
   assign scan_ctl.clear  = accept;
   assign scan_ctl.sample = rd_vld_ff;
   assign rd_en           = (state_ff == ST_SCAN);

   // Page memory: read during scan, written with the new page on a miss
   lrup_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (FRAMES),
      .AW    (IDX_W)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (commit && miss),
      .wr_addr (slot),
      .wr_data (page_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_page)
   );

   // Stamp memory: read during scan, refreshed for the used frame
   lrup_ram #(
      .WIDTH (CNT_W),
      .DEPTH (FRAMES),
      .AW    (IDX_W)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (slot),
      .wr_data (req_clock_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_stamp)
   );

   lrup_scan #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W)
   ) u_scan (
      .clock       (clock),
      .ctl         (scan_ctl),
      .entry_idx   (rd_idx_ff),
      .entry_valid (valid_ff[rd_idx_ff]),
      .entry_page  (rd_page),
      .entry_stamp (rd_stamp),
      .ref_page    (page_ff),
      .flags       (scan_flags),
      .hit_idx     (hit_idx),
      .empty_idx   (empty_idx),
      .min_idx     (min_idx),
      .min_page    (min_page)
   );

   // Sequencer, counters, valid bits and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CSR_RESET;
         valid_ff     <= '0;
         req_clock_ff <= '0;
         fault_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_data;
         end
         // drop a result once taken; a load below overrides
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= rd_en;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_clock_ff <= clock_inc;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (cnt_ff == last_ff) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (miss) begin
                  valid_ff[slot] <= 1'b1;
                  if (fault_ff != CNT_MAX) begin
                     fault_ff <= fault_ff + CNT_W'(1);
                  end
               end
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Payload registers: item page, scan address, held and output result
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= page_in;
         last_ff <= last_in;
         cnt_ff  <= '0;
      end else if (state_ff == ST_SCAN) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
      rd_idx_ff <= cnt_ff;
      if (commit) begin
         res_hit_ff  <= scan_flags.hit_found;
         res_slot_ff <= slot;
         res_evv_ff  <= evict;
         res_evp_ff  <= evict ? old_page_wide[PAGE_W-1:0] : '0;
      end
      if ((state_ff == ST_PUSH) && out_free) begin
         rsp_hit_ff   <= res_hit_ff;
         rsp_slot_ff  <= slot_wide[SLOT_W-1:0];
         rsp_evv_ff   <= res_evv_ff;
         rsp_evp_ff   <= res_evp_ff;
         rsp_fault_ff <= fault_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_slot    = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evv_ff;
   assign rsp_evicted_page  = rsp_evp_ff;
   assign rsp_fault_count   = rsp_fault_ff;

`ifndef ASSERT_OFF
   // A resident page never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid)
      else $error("hit result reports an eviction");

   // Faults never outnumber requests
   a_fault_le_req: assert property (@(posedge clock) disable iff (reset)
      fault_ff <= req_clock_ff)
      else $error("fault total exceeds request clock");

   // Fault total never decreases
   a_fault_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fault_ff >= $past(fault_ff))
      else $error("fault total went backward");

   // An accepted item starts its scan in the next cycle
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && !scan_flags.hit_found)
      else $error("accepted item did not start a clean scan");

   // No memory entry arrives for sampling while idle
   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_vld_ff)
      else $error("scan sample while idle");
`endif

endmodule : lru_page_replacement

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for lru_page_replacement
// Drives page references through the request channel and checks each result
// item against a timestamp LRU predictor kept in step with the frame count
// register. A directed opening covers the extreme pages, hits, empty-frame
// fills, evictions, frame counts of zero and above the table size, shrinking
// and duplicate resident pages. Random segments follow, built from working
// sets of pages under several frame counts and three idling patterns.
// ----------------------------------------------------------------------------
module testbench;
   import lrup_pkg::*;

   localparam int NFRAMES     = FRAMES_DEF;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int SEG_ITEMS   = 80;
   localparam int POOL_SIZE   = 40;

   typedef enum logic [1:0] {STEP_PAGE, STEP_CSR, STEP_DRAIN, STEP_PACE} step_kind_type;

   typedef struct {
      step_kind_type     kind;
      logic [PAGE_W-1:0] value;
      int                send_pct;
      int                recv_pct;
   } plan_step_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              ev_valid;
      logic [PAGE_W-1:0] ev_page;
      logic [CNT_W-1:0]  faults;
   } page_outcome_type;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [PAGE_W-1:0] req_page_number = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_frame_slot;
   logic              rsp_evicted_valid;
   logic [PAGE_W-1:0] rsp_evicted_page;
   logic [CNT_W-1:0]  rsp_fault_count;
   logic              csr_valid       = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_data        = '0;

   // predictor copy of the frame table and counters
   logic [PAGE_W-1:0] frame_page_m  [NFRAMES];
   logic              frame_valid_m [NFRAMES];
   logic [CNT_W-1:0]  frame_stamp_m [NFRAMES];
   logic [CNT_W-1:0]  use_clock_m   = '0;
   logic [CNT_W-1:0]  fault_total_m = '0;
   logic [CSR_W-1:0]  frames_cfg    = CSR_RESET;

   plan_step_type    ref_plan[$];
   page_outcome_type pending_outcomes[$];

   int n_sent      = 0;
   int n_seen      = 0;
   int send_pct    = 0;
   int recv_pct    = 0;
   int errors      = 0;
   int hits        = 0;
   int evictions   = 0;
   int csr_writes  = 0;
   int drains      = 0;
   int quiet_count = 0;

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < NFRAMES; i++) begin
         frame_valid_m[i] = 1'b0;
         frame_page_m[i]  = '0;
         frame_stamp_m[i] = '0;
      end
   end

   // Look up one page reference, update the table and return the outcome
   function automatic page_outcome_type lookup_page(logic [PAGE_W-1:0] page);
      page_outcome_type res;
      int            active;
      int            slot;
      logic          found;
      logic [CNT_W-1:0] least;
      res    = '0;
      active = (frames_cfg == 0) ? 1 : ((frames_cfg > NFRAMES) ? NFRAMES : int'(frames_cfg));
      slot   = 0;
      found  = 1'b0;
      if (use_clock_m != CNT_MAX) use_clock_m = use_clock_m + 1;
      // lowest matching frame wins
      for (int j = 0; j < active; j++) begin
         if (!found && frame_valid_m[j] && frame_page_m[j] == page) begin
            found = 1'b1;
            slot  = j;
         end
      end
      res.hit = found;
      if (!found) begin
         // fill the lowest empty frame
         for (int j = 0; j < active; j++) begin
            if (!found && !frame_valid_m[j]) begin
               found = 1'b1;
               slot  = j;
            end
         end
         // otherwise replace the oldest stamp, lowest index on ties
         if (!found) begin
            least = frame_stamp_m[0];
            slot  = 0;
            for (int j = 1; j < active; j++) begin
               if (frame_stamp_m[j] < least) begin
                  least = frame_stamp_m[j];
                  slot  = j;
               end
            end
            res.ev_valid = 1'b1;
            res.ev_page  = frame_page_m[slot];
         end
         frame_valid_m[slot] = 1'b1;
         frame_page_m[slot]  = page;
         if (fault_total_m != CNT_MAX) fault_total_m = fault_total_m + 1;
      end
      frame_stamp_m[slot] = use_clock_m;
      res.slot   = slot[SLOT_W-1:0];
      res.faults = fault_total_m;
      return res;
   endfunction

   task automatic add_step(step_kind_type kind, int value, int s_pct, int r_pct);
      plan_step_type st;
      st.kind     = kind;
      st.value    = value[PAGE_W-1:0];
      st.send_pct = s_pct;
      st.recv_pct = r_pct;
      ref_plan.push_back(st);
   endtask

   // Driver: present plan steps, predict each accepted item
   always @(posedge clock) begin : drive_req
      logic              req_taken;
      logic              idle_now;
      logic              nxt_valid;
      logic [PAGE_W-1:0] nxt_page;
      logic              nxt_csr;
      logic [CSR_W-1:0]  nxt_data;
      page_outcome_type  outcome;
      req_taken = req_valid && !req_stall;
      nxt_valid = req_valid && !req_taken;
      nxt_page  = req_page_number;
      nxt_csr   = csr_valid && !csr_ready;
      nxt_data  = csr_data;
      if (reset) begin
         nxt_valid = 1'b0;
         nxt_csr   = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            frames_cfg = csr_data;
            csr_writes++;
         end
         if (req_taken) begin
            outcome = lookup_page(req_page_number);
            pending_outcomes.push_back(outcome);
            if (outcome.hit) hits++;
            if (outcome.ev_valid) evictions++;
            n_sent <= n_sent + 1;
         end
         idle_now = !req_valid && (n_sent == n_seen);
         // advance the plan once nothing is pending on either channel
         if (!nxt_valid && !nxt_csr && ref_plan.size() != 0) begin
            case (ref_plan[0].kind)
               STEP_PAGE: begin
                  if ($urandom_range(99) >= send_pct) begin
                     nxt_valid = 1'b1;
                     nxt_page  = ref_plan[0].value;
                     void'(ref_plan.pop_front());
                  end
               end
               STEP_CSR: begin
                  if (idle_now) begin
                     nxt_csr  = 1'b1;
                     nxt_data = ref_plan[0].value[CSR_W-1:0];
                     void'(ref_plan.pop_front());
                  end
               end
               STEP_DRAIN: begin
                  if (idle_now) begin
                     drains++;
                     void'(ref_plan.pop_front());
                  end
               end
               default: begin
                  send_pct <= ref_plan[0].send_pct;
                  recv_pct <= ref_plan[0].recv_pct;
                  void'(ref_plan.pop_front());
               end
            endcase
         end
      end
      req_valid       <= nxt_valid;
      req_page_number <= nxt_page;
      csr_valid       <= nxt_csr;
      csr_data        <= nxt_data;
   end

   // Monitor: stall at random, check each accepted result item
   always @(posedge clock) begin : watch_rsp
      page_outcome_type want;
      rsp_stall <= ($urandom_range(99) < recv_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         n_seen <= n_seen + 1;
         if (pending_outcomes.size() == 0) begin
            $error("result item with no reference outstanding");
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
               errors++;
            end
            if (rsp_frame_slot !== want.slot) begin
               $error("frame_slot: expected %0d, got %0d", want.slot, rsp_frame_slot);
               errors++;
            end
            if (rsp_evicted_valid !== want.ev_valid) begin
               $error("evicted_valid: expected %0d, got %0d", want.ev_valid,
                      rsp_evicted_valid);
               errors++;
            end
            if (rsp_evicted_page !== want.ev_page) begin
               $error("evicted_page: expected %h, got %h", want.ev_page, rsp_evicted_page);
               errors++;
            end
            if (rsp_fault_count !== want.faults) begin
               $error("fault_count: expected %0d, got %0d", want.faults, rsp_fault_count);
               errors++;
            end
         end
      end
   end

   // Watchdog: end the run after too long without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_count <= 0;
         else
            quiet_count <= quiet_count + 1;
         if (quiet_count >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin : run
      int               cfg_list[6];
      int               eff;
      int               ws;
      int               pick;
      logic [PAGE_W-1:0] pool[POOL_SIZE];
      logic [PAGE_W-1:0] page;

      // directed opening: extremes, hits, fills, evictions
      add_step(STEP_PACE, 0, 7, 50);
      add_step(STEP_PAGE, 16'h0000, 0, 0);
      add_step(STEP_PAGE, 16'hFFFF, 0, 0);
      add_step(STEP_PAGE, 16'h0000, 0, 0);
      add_step(STEP_PAGE, 16'hFFFF, 0, 0);
      add_step(STEP_DRAIN, 0, 0, 0);
      // two frames: replace the least recently used
      add_step(STEP_CSR, 2, 0, 0);
      add_step(STEP_PAGE, 16'h0001, 0, 0);
      add_step(STEP_PAGE, 16'h5555, 0, 0);
      add_step(STEP_PAGE, 16'h0001, 0, 0);
      // zero frames acts as one; frame 1 drops out of the search
      add_step(STEP_CSR, 0, 0, 0);
      add_step(STEP_PAGE, 16'hAAAA, 0, 0);
      add_step(STEP_PAGE, 16'hAAAA, 0, 0);
      add_step(STEP_PAGE, 16'h5555, 0, 0);
      // oversized count saturates; duplicate page hits the lower frame
      add_step(STEP_CSR, 31, 0, 0);
      add_step(STEP_PAGE, 16'h5555, 0, 0);
      add_step(STEP_PAGE, 16'h1234, 0, 0);

      // random segments under three idling patterns
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       add_step(STEP_PACE, 0, 7, 50);
            1:       add_step(STEP_PACE, 0, 50, 7);
            default: add_step(STEP_PACE, 0, 0, 0);
         endcase
         cfg_list = '{1, 16, 0, 31, $urandom_range(2, 15), $urandom_range(17, 30)};
         for (int seg = 0; seg < 6; seg++) begin
            add_step(STEP_CSR, cfg_list[(seg + mode) % 6], 0, 0);
            eff = cfg_list[(seg + mode) % 6];
            eff = (eff == 0) ? 1 : ((eff > NFRAMES) ? NFRAMES : eff);
            for (int i = 0; i < POOL_SIZE; i++) pool[i] = PAGE_W'($urandom);
            for (int k = 0; k < SEG_ITEMS; k++) begin
               // resize the working set now and then
               if (k % 20 == 0) begin
                  ws = $urandom_range(1, (2 * eff + 2 > POOL_SIZE) ? POOL_SIZE : 2 * eff + 2);
               end
               pick = $urandom_range(99);
               if (pick < 75)
                  page = pool[$urandom_range(ws - 1)];
               else if (pick < 83)
                  page = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               else
                  page = PAGE_W'($urandom);
               add_step(STEP_PAGE, int'(page), 0, 0);
               if (k == SEG_ITEMS / 2 && $urandom_range(2) == 0) add_step(STEP_DRAIN, 0, 0, 0);
            end
         end
      end

      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // hold until every item is in and every result is back; sample between
      // edges so that the plan, the channels and the counts agree
      @(negedge clock);
      while (ref_plan.size() != 0 || req_valid || csr_valid || n_sent != n_seen)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d expected result items never arrived", pending_outcomes.size());
         errors++;
      end

      $display("run covered %0d references: %0d hits, %0d evictions", n_sent, hits,
               evictions);
      $display("with %0d frame-count writes and %0d full drains", csr_writes, drains);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
